@@ hdl/encvel_pkg.sv @@
// ============================================================================
// encvel_pkg
// Shared widths, constants, codes and types for the encoder velocity block.
// ============================================================================
package encvel_pkg;

   localparam int VEL_W       = 40;   // signed Q8 velocity
   localparam int CNT_W       = 32;   // encoder count
   localparam int TIME_W      = 32;   // microsecond timestamp
   localparam int RPC_W       = 32;   // radians per count, Q4.28
   localparam int WINDOW_W    = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int FUNC_W      = 2;
   localparam int ANG_W       = 64;   // angular outputs, signed Q16

   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_N_W     = 60;   // dividend / quotient width
   localparam int DIV_D_W     = 32;   // divisor / remainder width
   localparam int DIV_STEPS   = 2;    // quotient bits per cycle

   localparam int AV_SHIFT    = 20;   // Q8 * Q4.28 -> Q16
   localparam int POS_SHIFT   = 12;   // Q0 * Q4.28 -> Q16

   localparam int RING_DEPTH_DEFAULT = 16;

   localparam logic [MUL_W-1:0]    VEL_SCALE    = 32'd256000000; // 1e6 us/s * 256
   localparam logic [RPC_W-1:0]    RPC_RESET    = 32'd6588397;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd16;
   localparam logic [VEL_W-1:0]    VEL_MAX      = 40'h7F_FFFF_FFFF;
   localparam logic [VEL_W-1:0]    VEL_MIN      = 40'h80_0000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RPC     = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_VMUL,
      S_VDIV,
      S_VWAIT,
      S_SUM,
      S_DRAIN,
      S_MDIV,
      S_MWAIT,
      S_AVHI,
      S_AVLO,
      S_AVSUM,
      S_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

endpackage

@@ hdl/encoder_velocity_estimator_top.sv @@
// ============================================================================
// encoder_velocity_estimator_top
// One item in flight: the next item is accepted once the previous result is
// loaded into the output register. The ring read pass takes one entry per
// cycle; the shared 2-bit/cycle divider computes the mean always and the
// velocity on a stored sample. Reset is synchronous: ring entries read as
// zero, pointer, last count and last time are cleared.
// ============================================================================
module encoder_velocity_estimator_top #(
   parameter int RING_DEPTH = encvel_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [encvel_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [encvel_pkg::CNT_W-1:0]    req_encoder_count,
   input  logic [encvel_pkg::TIME_W-1:0]          req_time_us,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [encvel_pkg::VEL_W-1:0]    rsp_mean_velocity,
   output logic signed [encvel_pkg::ANG_W-1:0]    rsp_angular_velocity,
   output logic signed [encvel_pkg::ANG_W-1:0]    rsp_angular_position,
   output logic                                   rsp_sample_stored,
   // register write port
   input  logic                                   csr_we,
   input  logic [encvel_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [encvel_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int VEL_W  = encvel_pkg::VEL_W;
   localparam int CNT_W  = encvel_pkg::CNT_W;
   localparam int ANG_W  = encvel_pkg::ANG_W;
   localparam int MUL_W  = encvel_pkg::MUL_W;
   localparam int PROD_W = encvel_pkg::PROD_W;
   localparam int DIV_N_W = encvel_pkg::DIV_N_W;
   localparam int DIV_D_W = encvel_pkg::DIV_D_W;
   localparam int AV_SHIFT = encvel_pkg::AV_SHIFT;
   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int WIN_W  = $clog2(RING_DEPTH + 1);
   // worst-case window sum: RING_DEPTH entries of VEL_W bits
   localparam int SUM_W  = VEL_W + $clog2(RING_DEPTH);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic                                reverse_ff;
   logic [encvel_pkg::WINDOW_W-1:0]     window_ff;
   logic [encvel_pkg::RPC_W-1:0]        rpc_ff;

   // ---------------------------------------------------------------------
   // Sequencer and per-item registers
   // ---------------------------------------------------------------------
   encvel_pkg::state_type               state_ff;
   encvel_pkg::state_type               state_in;
   encvel_pkg::func_type                func_ff;
   logic signed [CNT_W-1:0]             count_ff;
   logic [encvel_pkg::TIME_W-1:0]       time_ff;
   logic [encvel_pkg::TIME_W-1:0]       dt_ff;
   logic [MUL_W-1:0]                    dmag_ff;    // |count delta|
   logic                                vneg_ff;    // velocity sign
   logic [MUL_W-1:0]                    pmag_ff;    // |adjusted count|
   logic                                pneg_ff;    // position sign
   logic [WIN_W-1:0]                    idx_ff;
   logic                                rd_pend_ff;
   logic [SUM_W-1:0]                    sum_ff;
   logic [VEL_W-1:0]                    mag_ff;     // |mean|
   logic [VEL_W-1:0]                    mean_ff;
   logic [PROD_W-1:0]                   avhi_ff;
   logic [ANG_W-1:0]                    av_ff;
   logic [ANG_W-1:0]                    pos_ff;
   logic                                stored_ff;

   // Persistent state outside the ring
   logic signed [CNT_W-1:0]             prev_count_ff;
   logic [encvel_pkg::TIME_W-1:0]       prev_time_ff;
   logic [PTR_W-1:0]                    ptr_ff;
   logic [PTR_W-1:0]                    ptr_in;

   // Output register
   logic                                rsp_valid_ff;
   logic [VEL_W-1:0]                    rsp_mean_ff;
   logic [ANG_W-1:0]                    rsp_av_ff;
   logic [ANG_W-1:0]                    rsp_pos_ff;
   logic                                rsp_stored_ff;

   // ---------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------
   logic                                accept;
   logic                                rsp_load;
   logic                                store;
   logic [WIN_W-1:0]                    win;
   logic [WIN_W-1:0]                    win_last;
   logic [WIN_W-1:0]                    ptr_nxt;
   logic [PTR_W-1:0]                    store_idx;
   logic [CNT_W:0]                      diff;
   logic [MUL_W-1:0]                    diff_mag;
   logic [MUL_W-1:0]                    cnt_mag;
   logic [SUM_W-1:0]                    sum_mag;
   logic                                sum_neg;
   logic [VEL_W-1:0]                    vsat;
   logic                                pos_ovf;
   logic                                neg_ovf;
   logic [PROD_W-1:0]                   av_mag;
   logic [PROD_W-1:0]                   ap_mag;

   // Shared units
   logic [MUL_W-1:0]                    mul_a;
   logic [MUL_W-1:0]                    mul_b;
   logic [PROD_W-1:0]                   mul_product;
   logic                                div_start;
   logic [DIV_N_W-1:0]                  div_dividend;
   logic [DIV_D_W-1:0]                  div_divisor;
   logic                                div_done;
   logic [DIV_N_W-1:0]                  div_quotient;
   encvel_pkg::ring_ctl_type            ring_ctl;
   logic [VEL_W-1:0]                    ring_rd_data;

   assign req_ready = (state_ff == encvel_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;

   // Active window: zero acts as one, oversize clamps to the ring depth
   always_comb begin
      if (window_ff == '0) begin
         win = WIN_W'(1);
      end else if (32'(window_ff) > RING_DEPTH) begin
         win = WIN_W'(RING_DEPTH);
      end else begin
         win = WIN_W'(window_ff);
      end
   end
   assign win_last = win - WIN_W'(1);

   // Pointer left beyond a shrunk window wraps to zero before the store
   assign store_idx = (WIN_W'(ptr_ff) >= win) ? '0 : ptr_ff;
   assign ptr_nxt   = WIN_W'(store_idx) + WIN_W'(1);
   assign ptr_in    = (ptr_nxt == win) ? '0 : PTR_W'(ptr_nxt);

   // Exact 33-bit count delta against the last latched count
   assign diff     = {req_encoder_count[CNT_W-1], req_encoder_count}
                   - {prev_count_ff[CNT_W-1], prev_count_ff};
   assign diff_mag = diff[CNT_W] ? MUL_W'((CNT_W+1)'(0) - diff) : diff[MUL_W-1:0];
   assign cnt_mag  = req_encoder_count[CNT_W-1] ? (MUL_W'(0) - MUL_W'(req_encoder_count))
                                                : MUL_W'(req_encoder_count);

   // Window sum sign/magnitude for the mean division
   assign sum_neg = sum_ff[SUM_W-1];
   assign sum_mag = sum_neg ? (SUM_W'(0) - sum_ff) : sum_ff;

   // Velocity: truncated magnitude quotient, signed, saturated to 40 bits
   assign pos_ovf = |div_quotient[DIV_N_W-1:VEL_W-1];
   assign neg_ovf = (|div_quotient[DIV_N_W-1:VEL_W])
                  | (div_quotient[VEL_W-1] & (|div_quotient[VEL_W-2:0]));
   always_comb begin
      if (vneg_ff) begin
         vsat = neg_ovf ? encvel_pkg::VEL_MIN : (VEL_W'(0) - div_quotient[VEL_W-1:0]);
      end else begin
         vsat = pos_ovf ? encvel_pkg::VEL_MAX : div_quotient[VEL_W-1:0];
      end
   end

   // |mean| * rpc >> 20 from two partial products: hi part already aligned
   assign av_mag = avhi_ff + (mul_product >> AV_SHIFT);
   assign ap_mag = mul_product >> encvel_pkg::POS_SHIFT;

   // ---------------------------------------------------------------------
   // Sequencer: next state, unit operands, ring control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      ring_ctl     = '0;
      div_start    = 1'b0;
      div_dividend = mul_product[DIV_N_W-1:0];
      div_divisor  = dt_ff;
      mul_a        = pmag_ff;
      mul_b        = rpc_ff;
      rsp_load     = 1'b0;
      store        = 1'b0;
      case (state_ff)
         encvel_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = encvel_pkg::S_POS;
            end
         end
         encvel_pkg::S_POS: begin
            // position product issued with default operands
            state_in = encvel_pkg::S_VMUL;
         end
         encvel_pkg::S_VMUL: begin
            mul_a = dmag_ff;
            mul_b = encvel_pkg::VEL_SCALE;
            if (func_ff == encvel_pkg::FUNC_SAMPLE && dt_ff != '0) begin
               state_in = encvel_pkg::S_VDIV;
            end else begin
               state_in = encvel_pkg::S_SUM;
            end
         end
         encvel_pkg::S_VDIV: begin
            div_start = 1'b1;
            state_in  = encvel_pkg::S_VWAIT;
         end
         encvel_pkg::S_VWAIT: begin
            if (div_done) begin
               store          = 1'b1;
               ring_ctl.wr_en = 1'b1;
               state_in       = encvel_pkg::S_SUM;
            end
         end
         encvel_pkg::S_SUM: begin
            ring_ctl.rd_en = 1'b1;
            if (idx_ff == win_last) begin
               state_in = encvel_pkg::S_DRAIN;
            end
         end
         encvel_pkg::S_DRAIN: begin
            state_in = encvel_pkg::S_MDIV;
         end
         encvel_pkg::S_MDIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_N_W'(sum_mag);
            div_divisor  = DIV_D_W'(win);
            state_in     = encvel_pkg::S_MWAIT;
         end
         encvel_pkg::S_MWAIT: begin
            if (div_done) begin
               state_in = encvel_pkg::S_AVHI;
            end
         end
         encvel_pkg::S_AVHI: begin
            mul_a    = MUL_W'(mag_ff[VEL_W-1:AV_SHIFT]);
            state_in = encvel_pkg::S_AVLO;
         end
         encvel_pkg::S_AVLO: begin
            mul_a    = MUL_W'(mag_ff[AV_SHIFT-1:0]);
            state_in = encvel_pkg::S_AVSUM;
         end
         encvel_pkg::S_AVSUM: begin
            state_in = encvel_pkg::S_OUT;
         end
         encvel_pkg::S_OUT: begin
            // output register frees up once the previous result transfers
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = encvel_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = encvel_pkg::S_IDLE;
         end
      endcase
      ring_ctl.clear = accept && (req_func == encvel_pkg::FUNC_CLEAR);
   end

   // ---------------------------------------------------------------------
   // Control and persistent state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= encvel_pkg::S_IDLE;
         reverse_ff    <= 1'b0;
         window_ff     <= encvel_pkg::WINDOW_RESET;
         rpc_ff        <= encvel_pkg::RPC_RESET;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         ptr_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= ring_ctl.rd_en;

         if (csr_we) begin
            case (csr_index)
               encvel_pkg::CSR_REVERSE: reverse_ff <= csr_wdata[0];
               encvel_pkg::CSR_WINDOW:  window_ff  <= csr_wdata[encvel_pkg::WINDOW_W-1:0];
               encvel_pkg::CSR_RPC:     rpc_ff     <= csr_wdata[encvel_pkg::RPC_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            case (encvel_pkg::func_type'(req_func))
               encvel_pkg::FUNC_START: begin
                  prev_time_ff  <= req_time_us;
                  prev_count_ff <= req_encoder_count;
               end
               encvel_pkg::FUNC_CLEAR: begin
                  prev_count_ff <= '0;
               end
               default: ;
            endcase
         end else if (store) begin
            prev_time_ff  <= time_ff;
            prev_count_ff <= count_ff;
            ptr_ff        <= ptr_in;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Item datapath
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= encvel_pkg::func_type'(req_func);
         count_ff  <= req_encoder_count;
         time_ff   <= req_time_us;
         dt_ff     <= req_time_us - prev_time_ff;
         dmag_ff   <= diff_mag;
         vneg_ff   <= diff[CNT_W] ^ reverse_ff;
         pmag_ff   <= cnt_mag;
         pneg_ff   <= req_encoder_count[CNT_W-1] ^ reverse_ff;
         idx_ff    <= '0;
         sum_ff    <= '0;
         stored_ff <= 1'b0;
      end else begin
         if (state_ff == encvel_pkg::S_SUM) begin
            idx_ff <= idx_ff + WIN_W'(1);
         end
         if (rd_pend_ff) begin
            sum_ff <= sum_ff + SUM_W'($signed(ring_rd_data));
         end
         if (store) begin
            stored_ff <= 1'b1;
         end
      end

      if (state_ff == encvel_pkg::S_VMUL) begin
         pos_ff <= pneg_ff ? (ANG_W'(0) - ANG_W'(ap_mag)) : ANG_W'(ap_mag);
      end
      if (state_ff == encvel_pkg::S_MWAIT && div_done) begin
         mag_ff  <= div_quotient[VEL_W-1:0];
         mean_ff <= sum_neg ? (VEL_W'(0) - div_quotient[VEL_W-1:0])
                            : div_quotient[VEL_W-1:0];
      end
      if (state_ff == encvel_pkg::S_AVLO) begin
         avhi_ff <= mul_product;
      end
      if (state_ff == encvel_pkg::S_AVSUM) begin
         av_ff <= sum_neg ? (ANG_W'(0) - ANG_W'(av_mag)) : ANG_W'(av_mag);
      end

      if (rsp_load) begin
         rsp_mean_ff   <= mean_ff;
         rsp_av_ff     <= av_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_stored_ff <= stored_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mean_velocity    = $signed(rsp_mean_ff);
   assign rsp_angular_velocity = $signed(rsp_av_ff);
   assign rsp_angular_position = $signed(rsp_pos_ff);
   assign rsp_sample_stored    = rsp_stored_ff;

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   encvel_ring #(
      .DEPTH (RING_DEPTH),
      .PTR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .wr_addr (store_idx),
      .wr_data (vsat),
      .rd_addr (idx_ff[PTR_W-1:0]),
      .rd_data (ring_rd_data)
   );

   encvel_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   encvel_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_product)
   );

endmodule

@@ hdl/encvel_ring.sv @@
// ============================================================================
// encvel_ring
// Velocity ring memory: one write port, one registered read port, per-entry
// valid bits so that a clear takes effect at once.
// ============================================================================
module encvel_ring #(
   parameter int DEPTH = encvel_pkg::RING_DEPTH_DEFAULT,
   parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  encvel_pkg::ring_ctl_type        ctl,
   input  logic [PTR_W-1:0]                wr_addr,
   input  logic [encvel_pkg::VEL_W-1:0]    wr_data,
   input  logic [PTR_W-1:0]                rd_addr,
   output logic [encvel_pkg::VEL_W-1:0]    rd_data
);

   logic [encvel_pkg::VEL_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]             valid_ff;
   logic [encvel_pkg::VEL_W-1:0] rd_raw_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written or cleared entries read as zero
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

@@ hdl/encvel_div.sv @@
// ============================================================================
// encvel_div
// Shared unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// ============================================================================
module encvel_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [encvel_pkg::DIV_N_W-1:0]    dividend,
   input  logic [encvel_pkg::DIV_D_W-1:0]    divisor,
   output logic                              done,
   output logic [encvel_pkg::DIV_N_W-1:0]    quotient
);

   localparam int N      = encvel_pkg::DIV_N_W;
   localparam int D      = encvel_pkg::DIV_D_W;
   localparam int ITER   = N / encvel_pkg::DIV_STEPS;
   localparam int CNT_BW = $clog2(ITER + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_BW-1:0] cnt_ff;
   logic [D-1:0]      rem_ff;
   logic [D-1:0]      rem_in;
   logic [N-1:0]      quo_ff;
   logic [N-1:0]      quo_in;
   logic [D-1:0]      den_ff;
   logic [D:0]        trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int s = 0; s < encvel_pkg::DIV_STEPS; s++) begin
         trial = {rem_in, quo_in[N-1]};
         if (trial >= {1'b0, den_ff}) begin
            trial  = trial - {1'b0, den_ff};
            quo_in = {quo_in[N-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[N-2:0], 1'b0};
         end
         rem_in = trial[D-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BW'(ITER);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BW'(1);
            if (cnt_ff == CNT_BW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/encvel_mul.sv @@
// ============================================================================
// encvel_mul
// Shared unsigned 32x32 multiplier with registered product.
// ============================================================================
module encvel_mul (
   input  logic                             clock,
   input  logic [encvel_pkg::MUL_W-1:0]     op_a,
   input  logic [encvel_pkg::MUL_W-1:0]     op_b,
   output logic [encvel_pkg::PROD_W-1:0]    product
);

   logic [encvel_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= encvel_pkg::PROD_W'(op_a) * encvel_pkg::PROD_W'(op_b);
   end

   assign product = product_ff;

endmodule

@@ verif/encoder_velocity_estimator_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Encoder velocity estimator testbench
// The bench drives count/timestamp items through the valid/ready request
// channel. It checks every response against a cycle-free model of the
// velocity ring, the windowed mean and the angular scaling. It runs several
// register settings, random stalls on both sides and one long response
// hold-off.
// ============================================================================

typedef struct {
   logic signed [encvel_pkg::VEL_W-1:0] mean_velocity;
   logic signed [encvel_pkg::ANG_W-1:0] angular_velocity;
   logic signed [encvel_pkg::ANG_W-1:0] angular_position;
   logic                                sample_stored;
} velocity_result_type;

class velocity_scoreboard;
   localparam int     VEL_W              = encvel_pkg::VEL_W;
   localparam int     CNT_W              = encvel_pkg::CNT_W;
   localparam int     TIME_W             = encvel_pkg::TIME_W;
   localparam int     RPC_W              = encvel_pkg::RPC_W;
   localparam int     WINDOW_W           = encvel_pkg::WINDOW_W;
   localparam int     RING_DEPTH_DEFAULT = encvel_pkg::RING_DEPTH_DEFAULT;
   localparam int     AV_SHIFT           = encvel_pkg::AV_SHIFT;
   localparam int     POS_SHIFT          = encvel_pkg::POS_SHIFT;
   localparam longint VEL_CEIL  = 64'sd549755813887;
   localparam longint VEL_FLOOR = -64'sd549755813888;

   bit                      reverse_dir;
   logic [WINDOW_W-1:0]     window_reg;
   logic [RPC_W-1:0]        rpc_reg;
   logic signed [VEL_W-1:0] ring [RING_DEPTH_DEFAULT];
   int unsigned             ring_ptr;
   longint                  last_count;
   logic [TIME_W-1:0]       last_time;
   velocity_result_type     expected_results[$];
   int                      error_count;

   function new();
      reverse_dir = 1'b0;
      window_reg  = encvel_pkg::WINDOW_RESET;
      rpc_reg     = encvel_pkg::RPC_RESET;
      foreach (ring[i]) ring[i] = '0;
      ring_ptr    = 0;
      last_count  = 0;
      last_time   = '0;
      error_count = 0;
   endfunction

   function void set_config(bit rev, logic [WINDOW_W-1:0] win, logic [RPC_W-1:0] rpc);
      reverse_dir = rev;
      window_reg  = win;
      rpc_reg     = rpc;
   endfunction

   // out-of-range window values clamp to 1..depth
   function int unsigned active_window();
      if (window_reg == 0) return 1;
      if (window_reg > RING_DEPTH_DEFAULT) return RING_DEPTH_DEFAULT;
      return window_reg;
   endfunction

   // update the model state for one accepted item and queue its response
   function void note_item(encvel_pkg::func_type f, logic signed [CNT_W-1:0] cnt,
                           logic [TIME_W-1:0] now);
      int unsigned         w;
      logic [TIME_W-1:0]   dt;
      longint              dt_l, scale_l, w_l;
      longint              delta, vel, sum, mean, pos;
      logic [63:0]         vmag, pmag, av, ap;
      logic [127:0]        vprod;
      velocity_result_type r;

      w = active_window();
      r.sample_stored = 1'b0;
      case (f)
         encvel_pkg::FUNC_START: begin
            last_time  = now;
            last_count = cnt;
         end
         encvel_pkg::FUNC_SAMPLE: begin
            dt = now - last_time;
            if (dt != 0) begin
               dt_l    = dt;
               scale_l = encvel_pkg::VEL_SCALE;
               delta   = longint'(cnt) - last_count;
               if (reverse_dir) delta = -delta;
               vel = (delta * scale_l) / dt_l;
               if (vel > VEL_CEIL) vel = VEL_CEIL;
               if (vel < VEL_FLOOR) vel = VEL_FLOOR;
               if (ring_ptr >= w) ring_ptr = 0;
               ring[ring_ptr] = vel[VEL_W-1:0];
               ring_ptr   = (ring_ptr + 1) % w;
               last_time  = now;
               last_count = cnt;
               r.sample_stored = 1'b1;
            end
         end
         encvel_pkg::FUNC_CLEAR: begin
            foreach (ring[i]) ring[i] = '0;
            last_count = 0;
         end
         default: ;
      endcase

      sum = 0;
      for (int i = 0; i < w; i++) sum += ring[i];
      w_l  = w;
      mean = sum / w_l;
      vmag = (mean < 0) ? -mean : mean;
      vprod = vmag * rpc_reg;
      av   = vprod >> AV_SHIFT;
      pos  = reverse_dir ? -longint'(cnt) : longint'(cnt);
      pmag = (pos < 0) ? -pos : pos;
      ap   = (pmag * rpc_reg) >> POS_SHIFT;

      r.mean_velocity    = mean[VEL_W-1:0];
      r.angular_velocity = (mean < 0) ? -av : av;
      r.angular_position = (pos < 0) ? -ap : ap;
      expected_results.push_back(r);
   endfunction

   function void check_result(logic signed [VEL_W-1:0] mean_v,
                              logic signed [encvel_pkg::ANG_W-1:0] ang_v,
                              logic signed [encvel_pkg::ANG_W-1:0] ang_p, logic stored);
      velocity_result_type want;
      if (expected_results.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR %0t: response transfer with none expected (mean %0d)",
                     $realtime, mean_v);
         return;
      end
      want = expected_results.pop_front();
      if (want.mean_velocity !== mean_v || want.angular_velocity !== ang_v ||
          want.angular_position !== ang_p || want.sample_stored !== stored) begin
         error_count++;
         if (error_count <= 10) begin
            $display("ERROR %0t: response mismatch (expected / actual)", $realtime);
            $display("  mean_velocity    %0d / %0d", want.mean_velocity, mean_v);
            $display("  angular_velocity %0d / %0d", want.angular_velocity, ang_v);
            $display("  angular_position %0d / %0d", want.angular_position, ang_p);
            $display("  sample_stored    %0d / %0d", want.sample_stored, stored);
         end
      end
   endfunction
endclass

module tb;

   localparam int VEL_W       = encvel_pkg::VEL_W;
   localparam int ANG_W       = encvel_pkg::ANG_W;
   localparam int CNT_W       = encvel_pkg::CNT_W;
   localparam int TIME_W      = encvel_pkg::TIME_W;
   localparam int RPC_W       = encvel_pkg::RPC_W;
   localparam int WINDOW_W    = encvel_pkg::WINDOW_W;
   localparam int CSR_INDEX_W = encvel_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = encvel_pkg::CSR_DATA_W;

   // no transfer on either channel for this many cycles ends the run
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int PHASE_COUNT = 8;
   // response hold-off: starts after this many responses, lasts this long
   localparam int HOLD_AFTER = 500;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 100;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   encvel_pkg::func_type    req_func = encvel_pkg::FUNC_NOP;
   logic signed [CNT_W-1:0] req_encoder_count = '0;
   logic [TIME_W-1:0]       req_time_us = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VEL_W-1:0] rsp_mean_velocity;
   logic signed [ANG_W-1:0] rsp_angular_velocity;
   logic signed [ANG_W-1:0] rsp_angular_position;
   logic                    rsp_sample_stored;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = encvel_pkg::CSR_REVERSE;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   velocity_scoreboard sb = new();

   bit                      quiet_phase = 1'b0;   // no idling on either side
   int                      results_seen = 0;
   int                      hold_left = 0;
   int                      idle_cycles = 0;
   logic signed [CNT_W-1:0] stim_count = '0;
   logic [TIME_W-1:0]       stim_time = '0;

   encoder_velocity_estimator_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_encoder_count    (req_encoder_count),
      .req_time_us          (req_time_us),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mean_velocity    (rsp_mean_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_angular_position (rsp_angular_position),
      .rsp_sample_stored    (rsp_sample_stored),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each transfer, then pick ready for the next edge.
   // Signals read right after the edge still hold their pre-edge values.
   // After HOLD_AFTER responses, ready stays low for HOLD_CYCLES so the
   // block holds its result and backs up the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_mean_velocity, rsp_angular_velocity,
                            rsp_angular_position, rsp_sample_stored);
            results_seen++;
            if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // watchdog: a hung handshake on either side ends the run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one item and return at the edge of its transfer. Valid is left
   // high so a back-to-back item keeps it up; it only drops for a gap.
   task automatic send_item(encvel_pkg::func_type f, logic signed [CNT_W-1:0] cnt,
                            logic [TIME_W-1:0] t);
      int gap;
      gap = 0;
      if (!quiet_phase)
         while ($urandom_range(0, 99) < 11) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= f;
      req_encoder_count <= cnt;
      req_time_us       <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_item(f, cnt, t);
   endtask

   // stop offering and wait until every queued response has arrived
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   // all three registers, one per cycle; unused upper data bits get junk
   task automatic write_settings(bit rev, logic [WINDOW_W-1:0] win, logic [RPC_W-1:0] rpc);
      csr_we    <= 1'b1;
      csr_index <= encvel_pkg::CSR_REVERSE;
      csr_wdata <= ($urandom() & ~32'h1) | rev;
      @(posedge clock);
      csr_index <= encvel_pkg::CSR_WINDOW;
      csr_wdata <= ($urandom() & ~32'h1F) | win;
      @(posedge clock);
      csr_index <= encvel_pkg::CSR_RPC;
      csr_wdata <= rpc;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(rev, win, rpc);
   endtask

   function automatic logic [TIME_W-1:0] pick_time_step();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 5) return '0;                       // zero time step
      if (k < 65) return $urandom_range(1, 2000);
      if (k < 90) return $urandom_range(1, 1 << 20);
      return $urandom();
   endfunction

   function automatic int pick_count_step();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 60) return int'($urandom_range(0, 4000)) - 2000;
      if (k < 90) return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      return int'($urandom());
   endfunction

   // Mostly a plausible motion: latch, then samples with moving count and
   // time. The rest is clears, no-ops and fully random items.
   task automatic send_random_item();
      int unsigned             k;
      encvel_pkg::func_type    f;
      logic signed [CNT_W-1:0] c;
      logic [TIME_W-1:0]       t;
      k = $urandom_range(0, 99);
      if (k < 65) begin
         f = encvel_pkg::FUNC_SAMPLE;
         t = stim_time + pick_time_step();
         c = stim_count + pick_count_step();
      end else if (k < 75) begin
         f = encvel_pkg::FUNC_START;
         t = stim_time + pick_time_step();
         c = stim_count + pick_count_step();
      end else if (k < 80) begin
         f = encvel_pkg::FUNC_CLEAR;
         t = stim_time + $urandom_range(0, 100);
         c = stim_count;
      end else if (k < 85) begin
         f = encvel_pkg::FUNC_NOP;
         t = $urandom();
         c = $urandom();
      end else begin
         f = encvel_pkg::func_type'($urandom_range(0, 3));
         t = $urandom();
         c = $urandom();
      end
      stim_time  = t;
      stim_count = c;
      send_item(f, c, t);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset settings (no reverse, full window)
      send_item(encvel_pkg::FUNC_START,  32'sd0, 32'd0);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sd0, 32'd0);                  // zero time step
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sd100, 32'd1000);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sd250, 32'd1500);
      send_item(encvel_pkg::FUNC_SAMPLE, -32'sd3, 32'd1507);              // negative, truncates
      send_item(encvel_pkg::FUNC_NOP,    32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(encvel_pkg::FUNC_START,  32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sh8000_0000, 32'h0000_0000);  // wrap, low clamp
      send_item(encvel_pkg::FUNC_START,  32'sh8000_0000, 32'd10);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sh7FFF_FFFF, 32'd11);         // high clamp
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sh7FFF_FFFF, 32'd11);         // zero time step
      send_item(encvel_pkg::FUNC_CLEAR,  32'sd12345, 32'd20);
      send_item(encvel_pkg::FUNC_SAMPLE, -32'sd1, 32'hFFFF_FFFF);         // huge dt, zero velocity
      send_item(encvel_pkg::FUNC_SAMPLE, -32'sd1, 32'hFFFF_FFFF);
      send_item(encvel_pkg::FUNC_CLEAR,  32'sh8000_0000, 32'd0);
      send_item(encvel_pkg::FUNC_START,  -32'sd5000, 32'hFFFF_FF00);
      send_item(encvel_pkg::FUNC_SAMPLE, -32'sd4000, 32'h0000_0010);      // timestamp wrap
      send_item(encvel_pkg::FUNC_SAMPLE, -32'sd4100, 32'h0000_0020);
      send_item(encvel_pkg::FUNC_NOP,    32'sh8000_0000, 32'h0000_0000);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sh7FFF_FFFF, 32'h0000_0021);
      send_item(encvel_pkg::FUNC_SAMPLE, 32'sh8000_0000, 32'h0000_0022);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // registers change only with the block empty
         drain_responses();
         quiet_phase = 1'b0;
         case (phase)
            0: write_settings(1'b1, 5'd1, 32'hFFFF_FFFF);
            1: write_settings(1'b0, 5'd0, 32'd0);             // window 0 acts as 1
            2: write_settings(1'b1, 5'd31, $urandom());       // above depth
            3: begin
               write_settings(1'b0, 5'd17, encvel_pkg::RPC_RESET);
               quiet_phase = 1'b1;                            // back-to-back stretch
            end
            4: write_settings(1'b0, 5'd16, $urandom());
            5: write_settings(1'b1, 5'($urandom_range(1, 16)), $urandom());
            6: write_settings(1'b0, 5'd2, 32'd1);
            default: write_settings(1'b1, 5'($urandom_range(0, 31)), $urandom());
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
      end

      drain_responses();
      quiet_phase = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

@@ files.f @@
hdl/encvel_pkg.sv
hdl/encvel_ring.sv
hdl/encvel_div.sv
hdl/encvel_mul.sv
hdl/encoder_velocity_estimator_top.sv
verif/encoder_velocity_estimator_tb.sv
